@@ design/aia_pkg.sv @@
// types and operation codes shared by the alpha integer alu modules
`default_nettype none

package aia_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned OP_W   = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADDQ    = 6'd0;
    localparam logic [OP_W-1:0] OP_SUBQ    = 6'd1;
    localparam logic [OP_W-1:0] OP_S4ADDQ  = 6'd2;
    localparam logic [OP_W-1:0] OP_S8ADDQ  = 6'd3;
    localparam logic [OP_W-1:0] OP_S4SUBQ  = 6'd4;
    localparam logic [OP_W-1:0] OP_S8SUBQ  = 6'd5;
    localparam logic [OP_W-1:0] OP_ADDL    = 6'd6;
    localparam logic [OP_W-1:0] OP_SUBL    = 6'd7;
    localparam logic [OP_W-1:0] OP_S4ADDL  = 6'd8;
    localparam logic [OP_W-1:0] OP_S8ADDL  = 6'd9;
    localparam logic [OP_W-1:0] OP_S4SUBL  = 6'd10;
    localparam logic [OP_W-1:0] OP_S8SUBL  = 6'd11;
    localparam logic [OP_W-1:0] OP_AND     = 6'd12;
    localparam logic [OP_W-1:0] OP_BIC     = 6'd13;
    localparam logic [OP_W-1:0] OP_BIS     = 6'd14;
    localparam logic [OP_W-1:0] OP_ORNOT   = 6'd15;
    localparam logic [OP_W-1:0] OP_XOR     = 6'd16;
    localparam logic [OP_W-1:0] OP_EQV     = 6'd17;
    localparam logic [OP_W-1:0] OP_ZAP     = 6'd18;
    localparam logic [OP_W-1:0] OP_ZAPNOT  = 6'd19;
    localparam logic [OP_W-1:0] OP_CMPEQ   = 6'd20;
    localparam logic [OP_W-1:0] OP_CMPLT   = 6'd21;
    localparam logic [OP_W-1:0] OP_CMPLE   = 6'd22;
    localparam logic [OP_W-1:0] OP_CMPULT  = 6'd23;
    localparam logic [OP_W-1:0] OP_CMPULE  = 6'd24;
    localparam logic [OP_W-1:0] OP_CMOVEQ  = 6'd25;
    localparam logic [OP_W-1:0] OP_CMOVNE  = 6'd26;
    localparam logic [OP_W-1:0] OP_CMOVLT  = 6'd27;
    localparam logic [OP_W-1:0] OP_CMOVGE  = 6'd28;
    localparam logic [OP_W-1:0] OP_CMOVLE  = 6'd29;
    localparam logic [OP_W-1:0] OP_CMOVGT  = 6'd30;
    localparam logic [OP_W-1:0] OP_CMOVLBS = 6'd31;
    localparam logic [OP_W-1:0] OP_CMOVLBC = 6'd32;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [DATA_W-1:0] old_destination;
    } in_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              written;
    } out_beat_t;

endpackage

`default_nettype wire

@@ design/aia_exec.sv @@
// execute logic: adder, logic unit, byte zap, compares and conditional moves
`default_nettype none

module aia_exec (
    input  wire aia_pkg::in_beat_t  op_in,
    output aia_pkg::out_beat_t      res_out
);

    logic [aia_pkg::DATA_W-1:0] a;
    logic [aia_pkg::DATA_W-1:0] b;
    logic [aia_pkg::DATA_W-1:0] sa;
    logic [aia_pkg::DATA_W-1:0] sum;
    logic [aia_pkg::DATA_W-1:0] arith;
    logic [aia_pkg::DATA_W-1:0] keep_mask;
    logic [1:0]                 scale;
    logic                       is_sub;
    logic                       is_long;
    logic                       a_neg;
    logic                       a_zero;
    logic                       cmov_ok;
    logic                       ult;
    logic                       slt;
    logic                       eq;

    assign a = op_in.operand_a;
    assign b = op_in.operand_b;

    // adder control for the twelve add/subtract forms
    always_comb begin
        scale   = 2'd0;
        is_sub  = 1'b0;
        is_long = 1'b0;
        case (op_in.operation)
            aia_pkg::OP_ADDQ:   begin scale = 2'd0; is_sub = 1'b0; end
            aia_pkg::OP_SUBQ:   begin scale = 2'd0; is_sub = 1'b1; end
            aia_pkg::OP_S4ADDQ: begin scale = 2'd2; is_sub = 1'b0; end
            aia_pkg::OP_S8ADDQ: begin scale = 2'd3; is_sub = 1'b0; end
            aia_pkg::OP_S4SUBQ: begin scale = 2'd2; is_sub = 1'b1; end
            aia_pkg::OP_S8SUBQ: begin scale = 2'd3; is_sub = 1'b1; end
            aia_pkg::OP_ADDL:   begin scale = 2'd0; is_sub = 1'b0; is_long = 1'b1; end
            aia_pkg::OP_SUBL:   begin scale = 2'd0; is_sub = 1'b1; is_long = 1'b1; end
            aia_pkg::OP_S4ADDL: begin scale = 2'd2; is_sub = 1'b0; is_long = 1'b1; end
            aia_pkg::OP_S8ADDL: begin scale = 2'd3; is_sub = 1'b0; is_long = 1'b1; end
            aia_pkg::OP_S4SUBL: begin scale = 2'd2; is_sub = 1'b1; is_long = 1'b1; end
            aia_pkg::OP_S8SUBL: begin scale = 2'd3; is_sub = 1'b1; is_long = 1'b1; end
            default: begin
                scale   = 2'd0;
                is_sub  = 1'b0;
                is_long = 1'b0;
            end
        endcase
    end

    assign sa  = a << scale;
    // subtract as add of the complement plus one
    assign sum = sa + (is_sub ? ~b : b) + {{(aia_pkg::DATA_W-1){1'b0}}, is_sub};
    assign arith = is_long ? {{(aia_pkg::DATA_W/2){sum[aia_pkg::DATA_W/2-1]}},
                              sum[aia_pkg::DATA_W/2-1:0]}
                           : sum;

    // bit i of the literal selects byte i
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            keep_mask[8*i +: 8] = {8{b[i]}};
        end
    end

    assign eq     = (a == b);
    assign ult    = (a < b);
    assign slt    = ($signed(a) < $signed(b));
    assign a_neg  = a[aia_pkg::DATA_W-1];
    assign a_zero = (a == '0);

    always_comb begin
        case (op_in.operation)
            aia_pkg::OP_CMOVEQ:  cmov_ok = a_zero;
            aia_pkg::OP_CMOVNE:  cmov_ok = !a_zero;
            aia_pkg::OP_CMOVLT:  cmov_ok = a_neg;
            aia_pkg::OP_CMOVGE:  cmov_ok = !a_neg;
            aia_pkg::OP_CMOVLE:  cmov_ok = a_neg || a_zero;
            aia_pkg::OP_CMOVGT:  cmov_ok = !a_neg && !a_zero;
            aia_pkg::OP_CMOVLBS: cmov_ok = a[0];
            aia_pkg::OP_CMOVLBC: cmov_ok = !a[0];
            default:             cmov_ok = 1'b0;
        endcase
    end

    always_comb begin
        res_out.written = 1'b1;
        case (op_in.operation)
            aia_pkg::OP_ADDQ, aia_pkg::OP_SUBQ, aia_pkg::OP_S4ADDQ,
            aia_pkg::OP_S8ADDQ, aia_pkg::OP_S4SUBQ, aia_pkg::OP_S8SUBQ,
            aia_pkg::OP_ADDL, aia_pkg::OP_SUBL, aia_pkg::OP_S4ADDL,
            aia_pkg::OP_S8ADDL, aia_pkg::OP_S4SUBL, aia_pkg::OP_S8SUBL:
                res_out.result = arith;
            aia_pkg::OP_AND:    res_out.result = a & b;
            aia_pkg::OP_BIC:    res_out.result = a & ~b;
            aia_pkg::OP_BIS:    res_out.result = a | b;
            aia_pkg::OP_ORNOT:  res_out.result = a | ~b;
            aia_pkg::OP_XOR:    res_out.result = a ^ b;
            aia_pkg::OP_EQV:    res_out.result = a ^ ~b;
            aia_pkg::OP_ZAP:    res_out.result = a & ~keep_mask;
            aia_pkg::OP_ZAPNOT: res_out.result = a & keep_mask;
            aia_pkg::OP_CMPEQ:
                res_out.result = {{(aia_pkg::DATA_W-1){1'b0}}, eq};
            aia_pkg::OP_CMPLT:
                res_out.result = {{(aia_pkg::DATA_W-1){1'b0}}, slt};
            aia_pkg::OP_CMPLE:
                res_out.result = {{(aia_pkg::DATA_W-1){1'b0}}, slt || eq};
            aia_pkg::OP_CMPULT:
                res_out.result = {{(aia_pkg::DATA_W-1){1'b0}}, ult};
            aia_pkg::OP_CMPULE:
                res_out.result = {{(aia_pkg::DATA_W-1){1'b0}}, ult || eq};
            default: begin
                // conditional moves and unused codes
                res_out.result  = cmov_ok ? b : op_in.old_destination;
                res_out.written = cmov_ok;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/alpha_integer_alu_top.sv @@
// alpha integer alu top level: input register, execute logic, result register
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_data  (aia_pkg::in_beat_t)
//  m_      | out | m_valid / m_ready  | m_data  (aia_pkg::out_beat_t)
//
// one beat in and one beat out per cycle when the sink keeps m_ready high
// a beat passes through the input register, then the execute logic, then the result register
// aresetn (synchronous, active low) empties both stages by clearing their valid flags only
// a stall on m_ready holds the result register, then the input register, then s_ready
`default_nettype none

module alpha_integer_alu_top (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire aia_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output aia_pkg::out_beat_t  m_data
);

    aia_pkg::in_beat_t  in_data_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    aia_pkg::out_beat_t out_data_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    aia_pkg::out_beat_t exec_res;
    logic               out_load;
    logic               in_load;

    // result register can take a beat when empty or being drained
    assign out_load = !out_valid_reg || m_ready;
    assign in_load  = !in_valid_reg || out_load;
    assign s_ready  = in_load;

    assign in_valid_next  = in_load ? s_valid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_valid) begin
            in_data_reg <= s_data;
        end
        if (out_load && in_valid_reg) begin
            out_data_reg <= exec_res;
        end
    end

    aia_exec u_exec (
        .op_in   (in_data_reg),
        .res_out (exec_res)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // an accepted beat always lands in the input register
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted beat not held in input register");

    // a beat in the input register is never dropped while the output stalls
    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a beat under stall");

    // a pending input beat moves to the result register when that register is empty or draining
    a_in_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_load |=> out_valid_reg)
        else $error("beat not forwarded to result register");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg)
        else $error("result register valid after reset");

endmodule

`default_nettype wire
